// ===== design/scfp_pkg.sv =====
package scfp_pkg;

   // Largest frame, header through trailer, that the frame store takes.
   localparam int unsigned MAX_FRAME_BYTES = 20;

   // Frame positions and accepted lengths both stay below 32.
   localparam int unsigned POS_W = 5;

   localparam logic [7:0] HDR_FIRST  = 8'hAE;
   localparam logic [7:0] HDR_SECOND = 8'hEA;
   localparam logic [7:0] TRL_FIRST  = 8'hEF;
   localparam logic [7:0] TRL_SECOND = 8'hFE;
   localparam logic [7:0] SPEED_CMD  = 8'hE3;

   // Frame position of the command byte, and counts of the stored payload bytes and of the kept speed bytes.
   localparam int unsigned CMD_POS     = 3;
   localparam int unsigned PAYLOAD_CNT = 5;
   localparam int unsigned KEPT_CNT    = 4;

   typedef struct packed {
      logic [7:0]         frame_command;
      logic signed [15:0] speed_left;
      logic signed [15:0] speed_right;
      logic               speed_valid;
   } scfp_result_type;

endpackage

// ===== design/speed_command_frame_parser_core.sv =====
// Speed command frame parser. Each input transfer carries one byte received
// from the serial link; the bytes AE EA in a row start a frame from any state,
// followed by a length byte L, L-1 more bytes and the trailer EF FE. When the
// trailer completes, one result transfer carries the command byte at frame
// position 3 and two big-endian signed speeds from positions 4 to 7; the speeds
// are nonzero only for the speed command E3. Speed bytes at the trailer of a
// short frame take the trailer bytes, and those past it repeat those of the
// last completed frame. Any unexpected byte, or a length that would not fit a
// 20-byte frame, drops the frame without a result; the checksum is not checked.
// The frame state is updated at the edge that accepts the byte, and a finished
// result is loaded into the output register at that same edge. A new byte is
// accepted in every cycle in which the output register is empty or its result
// is taken, so throughput is one byte per clock unless the result side stalls.
module speed_command_frame_parser_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_frame_command,
   output logic signed [15:0] rsp_speed_left,
   output logic signed [15:0] rsp_speed_right,
   output logic               rsp_speed_valid
);
   import scfp_pkg::*;

   logic            req_transfer;
   logic            frame_done;
   scfp_result_type frame_result;

   logic            rsp_valid_ff, rsp_valid_in;
   scfp_result_type rsp_data_ff, rsp_data_in;

   // The output register may be refilled in the same cycle its result leaves.
   assign req_ready    = !rsp_valid_ff || rsp_ready;
   assign req_transfer = req_valid && req_ready;

   scfp_frame_tracker u_tracker (
      .clock       (clock),
      .reset       (reset),
      .byte_strobe (req_transfer),
      .rx_byte     (req_rx_byte),
      .done        (frame_done),
      .result      (frame_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      // A completed frame always finds the output register free, since bytes
      // are only taken when it is empty or draining.
      if (frame_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = frame_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The result payload needs no reset; it is qualified by the valid flag.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_command = rsp_data_ff.frame_command;
   assign rsp_speed_left    = rsp_data_ff.speed_left;
   assign rsp_speed_right   = rsp_data_ff.speed_right;
   assign rsp_speed_valid   = rsp_data_ff.speed_valid;

endmodule

// ===== design/scfp_frame_tracker.sv =====
module scfp_frame_tracker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     byte_strobe,
   input  logic [7:0]               rx_byte,
   output logic                     done,
   output scfp_pkg::scfp_result_type result
);
   import scfp_pkg::*;

   logic [7:0]       previous_byte_ff, previous_byte_in;
   logic             in_frame_ff, in_frame_in;
   logic [POS_W-1:0] position_ff, position_in;
   logic [POS_W-1:0] length_ff, length_in;
   logic [7:0]       current_ff [PAYLOAD_CNT];
   logic [7:0]       current_in [PAYLOAD_CNT];
   logic [7:0]       kept_ff [KEPT_CNT];
   logic [7:0]       kept_in [KEPT_CNT];

   logic             header_seen;
   logic             length_too_big;
   logic [POS_W:0]   pos_ext;
   logic [POS_W:0]   trl_first_pos;
   logic [POS_W:0]   trl_second_pos;
   logic             store_byte;
   logic             finish;
   logic [POS_W:0]   last_pos;

   always_comb begin
      header_seen    = (previous_byte_ff == HDR_FIRST) && (rx_byte == HDR_SECOND);
      length_too_big = ({1'b0, rx_byte} + 9'd4) > 9'(MAX_FRAME_BYTES);
      pos_ext        = {1'b0, position_ff};
      trl_first_pos  = {1'b0, length_ff} + (POS_W+1)'(2);
      trl_second_pos = {1'b0, length_ff} + (POS_W+1)'(3);
      last_pos       = trl_second_pos;

      previous_byte_in = rx_byte;
      in_frame_in      = in_frame_ff;
      position_in      = position_ff;
      length_in        = length_ff;
      store_byte       = 1'b0;
      finish           = 1'b0;

      if (header_seen) begin
         in_frame_in = 1'b1;
         position_in = POS_W'(2);
      end else if (!in_frame_ff) begin
         position_in = '0;
      end else if (position_ff == POS_W'(2)) begin
         // Only frames whose length fits the frame store go on, so the
         // narrow length register is enough.
         length_in = rx_byte[POS_W-1:0];
         if (length_too_big) begin
            in_frame_in = 1'b0;
            position_in = '0;
         end else begin
            position_in = POS_W'(3);
         end
      end else if (pos_ext < trl_first_pos) begin
         store_byte = 1'b1;
      end else if ((pos_ext == trl_first_pos) && (rx_byte == TRL_FIRST)) begin
         store_byte = 1'b1;
      end else if ((pos_ext == trl_second_pos) && (rx_byte == TRL_SECOND)) begin
         store_byte = 1'b1;
         finish     = 1'b1;
      end else begin
         in_frame_in = 1'b0;
         position_in = '0;
      end

      if (store_byte) begin
         position_in = position_ff + POS_W'(1);
      end
      if (finish) begin
         in_frame_in = 1'b0;
         position_in = '0;
      end

      for (int i = 0; i < PAYLOAD_CNT; i++) begin
         current_in[i] = current_ff[i];
         if (store_byte && (position_ff == POS_W'(CMD_POS + i))) begin
            current_in[i] = rx_byte;
         end
      end

      // Speed bytes past a short frame's trailer keep the older value.
      for (int i = 0; i < KEPT_CNT; i++) begin
         kept_in[i] = kept_ff[i];
         if (finish && ((POS_W+1)'(CMD_POS + 1 + i) <= last_pos)) begin
            kept_in[i] = current_in[i+1];
         end
      end

      result.frame_command = current_in[0];
      result.speed_valid   = (current_in[0] == SPEED_CMD);
      if (result.speed_valid) begin
         result.speed_left  = {kept_in[0], kept_in[1]};
         result.speed_right = {kept_in[2], kept_in[3]};
      end else begin
         result.speed_left  = '0;
         result.speed_right = '0;
      end
      done = byte_strobe && finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_byte_ff <= '0;
         in_frame_ff      <= 1'b0;
         position_ff      <= '0;
         length_ff        <= '0;
         for (int i = 0; i < PAYLOAD_CNT; i++) begin
            current_ff[i] <= '0;
         end
         for (int i = 0; i < KEPT_CNT; i++) begin
            kept_ff[i] <= '0;
         end
      end else if (byte_strobe) begin
         previous_byte_ff <= previous_byte_in;
         in_frame_ff      <= in_frame_in;
         position_ff      <= position_in;
         length_ff        <= length_in;
         current_ff       <= current_in;
         kept_ff          <= kept_in;
      end
   end

endmodule
